// ===== design/udprc_pkg.sv =====
// udprc_pkg: shared types, constants and helpers for the udp receive checker
package udprc_pkg;

	// port table size and derived index width
	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	// udp framing constants
	localparam logic [15:0] HEADER_BYTES = 16'd8;
	localparam logic [15:0] UDP_PROTOCOL = 16'd17;

	// odd-byte pad word and pseudo header words folded in after the last byte
	localparam int FIN_WORDS = 7;
	localparam int FIN_BITS = FIN_WORDS * 16;
	localparam int STEP_W = $clog2(FIN_WORDS);

	// item modes
	localparam logic [1:0] MODE_BYTE  = 2'd0;
	localparam logic [1:0] MODE_OPEN  = 2'd1;
	localparam logic [1:0] MODE_CLOSE = 2'd2;

	// result status codes
	localparam logic [2:0] STAT_DELIVERED   = 3'd0;
	localparam logic [2:0] STAT_UNREACHABLE = 3'd1;
	localparam logic [2:0] STAT_BAD_SUM     = 3'd2;
	localparam logic [2:0] STAT_TOO_SHORT   = 3'd3;
	localparam logic [2:0] STAT_OPENED      = 3'd4;
	localparam logic [2:0] STAT_FULL        = 3'd5;
	localparam logic [2:0] STAT_CLOSED      = 3'd6;

	// input item
	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  data_byte;
		logic        last;
		logic [31:0] source_ip;
		logic [15:0] port_number;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  entry_index;
		logic [15:0] source_port;
		logic [15:0] destination_port;
		logic [15:0] payload_length;
		logic [15:0] computed_sum;
	} out_item_t;

	// control from the sequencer to the checksum unit
	typedef struct packed {
		logic byte_en;
		logic fin_step;
		logic clear;
	} sum_ctl_t;

	// status from the checksum unit
	typedef struct packed {
		logic        short_dgram;
		logic [15:0] computed;
		logic [15:0] hdr_sport;
		logic [15:0] dst_port;
		logic [15:0] rx_sum;
		logic [15:0] count;
	} sum_stat_t;

	// table update request
	typedef struct packed {
		logic        open;
		logic        close;
		logic [15:0] port;
	} tbl_op_t;

	// table search results
	typedef struct packed {
		logic             open_found;
		logic [IDX_W-1:0] open_idx;
		logic             lookup_hit;
		logic [IDX_W-1:0] lookup_idx;
	} tbl_res_t;

	// ones' complement add with end-around carry
	function automatic logic [15:0] oc_add(logic [15:0] a, logic [15:0] w);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, w};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	// table index reduced to the four-bit result field
	function automatic logic [3:0] to_entry(logic [IDX_W-1:0] idx);
		logic [IDX_W+3:0] t;
		t = (IDX_W + 4)'(idx);
		return t[3:0];
	endfunction

endpackage

// ===== design/udprc_sum.sv =====
// udprc_sum: byte-serial ones' complement checksum and header capture
module udprc_sum (
	input  logic                 clk,
	input  logic                 arst_n,
	input  udprc_pkg::sum_ctl_t  ctl,
	input  udprc_pkg::in_item_t  item,
	input  logic [31:0]          local_ip,
	output udprc_pkg::sum_stat_t stat
);

	logic [15:0] sum_q;
	logic [15:0] count_q;
	logic [7:0]  pend_q;
	logic        hp_q;
	logic [15:0] sp_q;
	logic [15:0] dp_q;
	logic [15:0] rc_q;
	logic [udprc_pkg::FIN_BITS-1:0] words_q;

	logic [7:0]  v;
	logic [15:0] next_count;
	logic [15:0] pad_word;

	// checksum field bytes count as zero
	always_comb begin
		v = item.data_byte;
		if (count_q == 16'd6 || count_q == 16'd7) begin
			v = 8'd0;
		end
		next_count = (count_q == 16'hFFFF) ? count_q : count_q + 16'd1;
		pad_word = hp_q ? 16'd0 : {v, 8'd0};
	end

	// byte accumulation, pseudo header fold and datagram clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			pend_q  <= '0;
			hp_q    <= 1'b0;
			sp_q    <= '0;
			dp_q    <= '0;
			rc_q    <= '0;
			words_q <= '0;
		end else if (ctl.clear) begin
			sum_q   <= '0;
			count_q <= '0;
			pend_q  <= '0;
			hp_q    <= 1'b0;
			sp_q    <= '0;
			dp_q    <= '0;
			rc_q    <= '0;
		end else if (ctl.byte_en) begin
			case (count_q)
				16'd0: sp_q <= {item.data_byte, 8'd0};
				16'd1: sp_q <= {sp_q[15:8], item.data_byte};
				16'd2: dp_q <= {item.data_byte, 8'd0};
				16'd3: dp_q <= {dp_q[15:8], item.data_byte};
				16'd6: rc_q <= {item.data_byte, 8'd0};
				16'd7: rc_q <= {rc_q[15:8], item.data_byte};
				default: ;
			endcase
			if (hp_q) begin
				sum_q <= udprc_pkg::oc_add(sum_q, {pend_q, v});
				hp_q  <= 1'b0;
			end else begin
				pend_q <= v;
				hp_q   <= 1'b1;
			end
			count_q <= next_count;
			// pseudo header words queued for the fold
			if (item.last) begin
				words_q <= {pad_word, item.source_ip[31:16], item.source_ip[15:0],
					local_ip[31:16], local_ip[15:0], udprc_pkg::UDP_PROTOCOL,
					next_count};
			end
		end else if (ctl.fin_step) begin
			sum_q   <= udprc_pkg::oc_add(sum_q,
				words_q[udprc_pkg::FIN_BITS-1 -: 16]);
			words_q <= {words_q[udprc_pkg::FIN_BITS-17:0], 16'd0};
		end
	end

	assign stat.short_dgram = next_count < udprc_pkg::HEADER_BYTES;
	assign stat.computed    = ~sum_q;
	assign stat.hdr_sport   = sp_q;
	assign stat.dst_port    = dp_q;
	assign stat.rx_sum      = rc_q;
	assign stat.count       = count_q;

endmodule

// ===== design/udprc_table.sv =====
// udprc_table: port table with parallel compare for open, close and lookup
module udprc_table (
	input  logic                clk,
	input  logic                arst_n,
	input  udprc_pkg::tbl_op_t  op,
	input  logic [15:0]         lookup_port,
	output udprc_pkg::tbl_res_t res
);

	localparam int N = udprc_pkg::TABLE_ENTRIES;
	localparam int W = udprc_pkg::IDX_W;

	logic [15:0] port_q [N];
	logic [N-1:0] valid_q;

	logic         match_hit;
	logic [W-1:0] match_idx;
	logic         free_hit;
	logic [W-1:0] free_idx;
	logic         look_hit;
	logic [W-1:0] look_idx;

	// lowest matching, lowest free and lowest delivering entry
	always_comb begin
		match_hit = 1'b0;
		match_idx = '0;
		free_hit  = 1'b0;
		free_idx  = '0;
		look_hit  = 1'b0;
		look_idx  = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (port_q[i] == op.port) begin
				match_hit = 1'b1;
				match_idx = W'(i);
			end
			if (!valid_q[i]) begin
				free_hit = 1'b1;
				free_idx = W'(i);
			end
			if (valid_q[i] && port_q[i] == lookup_port) begin
				look_hit = 1'b1;
				look_idx = W'(i);
			end
		end
	end

	assign res.open_found = match_hit || free_hit;
	assign res.open_idx   = match_hit ? match_idx : free_idx;
	assign res.lookup_hit = look_hit;
	assign res.lookup_idx = look_idx;

	// table updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				port_q[i] <= '0;
			end
			valid_q <= '0;
		end else if (op.open) begin
			if (match_hit) begin
				valid_q[match_idx] <= 1'b1;
			end else if (free_hit) begin
				valid_q[free_idx] <= 1'b1;
				port_q[free_idx]  <= op.port;
			end
		end else if (op.close) begin
			for (int i = 0; i < N; i++) begin
				if (port_q[i] == op.port) begin
					valid_q[i] <= 1'b0;
				end
			end
		end
	end

	// a successful open leaves its entry valid and holding the port
	assert property (@(posedge clk) disable iff (!arst_n)
		op.open && res.open_found |=> valid_q[$past(res.open_idx)] &&
			port_q[$past(res.open_idx)] == $past(op.port))
		else $error("open did not install its entry");

endmodule

// ===== design/udp_receive_checker_demux_core.sv =====
// udp_receive_checker_demux_core: udp checksum check and port demultiplexer
// table items and too-short datagrams load their result into the output register
// as they are transferred; a complete datagram's last byte starts the fold
// of the odd-byte pad word and six pseudo header words, one per cycle,
// then ST_DONE registers its result; input is held off for the whole fold
// bytes flow at one per cycle while the output register is free or being read
// reset clears local_ip, the running checksum state and the whole port table
module udp_receive_checker_demux_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  udprc_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output udprc_pkg::out_item_t out_data,
	input  logic                 cfg_wr_en,
	input  logic [31:0]          cfg_wr_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_FIN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [udprc_pkg::STEP_W-1:0] step_q;
	logic [31:0] local_ip_q;
	logic out_valid_q;
	udprc_pkg::out_item_t out_data_q;

	udprc_pkg::sum_ctl_t  sum_ctl;
	udprc_pkg::sum_stat_t sum_stat;
	udprc_pkg::tbl_op_t   tbl_op;
	udprc_pkg::tbl_res_t  tbl_res;

	logic xfer;
	logic byte_xfer;
	logic last_xfer;
	logic sum_ok;
	udprc_pkg::out_item_t dgram_res;
	udprc_pkg::out_item_t op_res;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign xfer      = in_valid && in_ready;
	assign byte_xfer = xfer && in_data.mode == udprc_pkg::MODE_BYTE;
	assign last_xfer = byte_xfer && in_data.last;

	// control to the units
	assign sum_ctl.byte_en  = byte_xfer;
	assign sum_ctl.fin_step = state_q == ST_FIN;
	assign sum_ctl.clear    = (state_q == ST_DONE) ||
		(last_xfer && sum_stat.short_dgram);
	assign tbl_op.open  = xfer && in_data.mode == udprc_pkg::MODE_OPEN;
	assign tbl_op.close = xfer && in_data.mode == udprc_pkg::MODE_CLOSE;
	assign tbl_op.port  = in_data.port_number;

	udprc_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (sum_ctl),
		.item     (in_data),
		.local_ip (local_ip_q),
		.stat     (sum_stat)
	);

	udprc_table u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (tbl_op),
		.lookup_port (sum_stat.dst_port),
		.res         (tbl_res)
	);

	// datagram verdict once the fold is complete
	always_comb begin
		sum_ok = sum_stat.rx_sum == 16'd0 || sum_stat.rx_sum == sum_stat.computed ||
			(sum_stat.computed == 16'd0 && sum_stat.rx_sum == 16'hFFFF);
		dgram_res.source_port      = sum_stat.hdr_sport;
		dgram_res.destination_port = sum_stat.dst_port;
		dgram_res.payload_length   = sum_stat.count - udprc_pkg::HEADER_BYTES;
		dgram_res.computed_sum     = sum_stat.computed;
		dgram_res.entry_index      = 4'd0;
		if (!sum_ok) begin
			dgram_res.status = udprc_pkg::STAT_BAD_SUM;
		end else if (tbl_res.lookup_hit) begin
			dgram_res.status      = udprc_pkg::STAT_DELIVERED;
			dgram_res.entry_index = udprc_pkg::to_entry(tbl_res.lookup_idx);
		end else begin
			dgram_res.status = udprc_pkg::STAT_UNREACHABLE;
		end
	end

	// result of a table item or a too-short datagram
	always_comb begin
		op_res = '0;
		if (tbl_op.close) begin
			op_res.status = udprc_pkg::STAT_CLOSED;
		end else if (tbl_op.open && tbl_res.open_found) begin
			op_res.status      = udprc_pkg::STAT_OPENED;
			op_res.entry_index = udprc_pkg::to_entry(tbl_res.open_idx);
		end else if (tbl_op.open) begin
			op_res.status = udprc_pkg::STAT_FULL;
		end else begin
			op_res.status = udprc_pkg::STAT_TOO_SHORT;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q <= '0;
		end else if (cfg_wr_en) begin
			local_ip_q <= cfg_wr_data;
		end
	end

	// sequencer for the pseudo header fold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (last_xfer && !sum_stat.short_dgram) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					step_q <= step_q + 1'b1;
					if (step_q == udprc_pkg::STEP_W'(udprc_pkg::FIN_WORDS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE) begin
			out_valid_q <= 1'b1;
		end else if (tbl_op.open || tbl_op.close ||
			(last_xfer && sum_stat.short_dgram)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_data_q <= '0;
		end else if (state_q == ST_DONE) begin
			out_data_q <= dgram_res;
		end else if (tbl_op.open || tbl_op.close ||
			(last_xfer && sum_stat.short_dgram)) begin
			out_data_q <= op_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// the output register is empty for the whole fold
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !out_valid_q)
		else $error("result pending while a datagram is being folded");

	// every completed fold produces a result
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |=> out_valid_q && $past(sum_ctl.clear))
		else $error("fold finished without a result");

	// the fold step never goes past the last word
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> step_q <= udprc_pkg::STEP_W'(udprc_pkg::FIN_WORDS - 1))
		else $error("fold step out of range");

endmodule

// ===== bench/tb_udp_receive_checker_demux_core.sv =====
// testbench for the udp receive checker: checksum verdicts and port table demux vs a predictor
module tb_udp_receive_checker_demux_core;
	timeunit 1ns;
	timeprecision 1ps;

	// mode code the block must ignore
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int POOL_SIZE = 24;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASE_ITEMS = 650;

	// how the checksum field of a generated datagram is filled
	typedef enum {SUM_GOOD, SUM_ABSENT, SUM_BAD, SUM_ZERO_RESULT} sum_plan_t;

	// expected verdicts for the transfers that give a result, plus its own copy of the block state
	class verdict_board;
		logic [31:0] local_ip;
		logic [15:0] run_sum;
		logic [15:0] byte_cnt;
		logic [7:0]  hi_byte;
		bit          hi_pending;
		logic [15:0] hdr_sport;
		logic [15:0] hdr_dport;
		logic [15:0] rx_sum;
		logic [15:0] port_tab[udprc_pkg::TABLE_ENTRIES];
		bit          port_live[udprc_pkg::TABLE_ENTRIES];
		udprc_pkg::out_item_t verdicts_due[$];
		int unsigned mismatch_count;

		function new();
			local_ip = '0;
			mismatch_count = 0;
			clear_datagram();
			foreach (port_tab[i]) begin
				port_tab[i] = '0;
				port_live[i] = 1'b0;
			end
		endfunction

		// end-around carry add of one 16-bit word
		static function logic [15:0] ones_add(logic [15:0] a, logic [15:0] w);
			logic [31:0] t;
			t = {16'h0, a} + {16'h0, w};
			t = {16'h0, t[15:0]} + {16'h0, t[31:16]};
			return t[15:0];
		endfunction

		function void clear_datagram();
			run_sum = '0;
			byte_cnt = '0;
			hi_byte = '0;
			hi_pending = 1'b0;
			hdr_sport = '0;
			hdr_dport = '0;
			rx_sum = '0;
		endfunction

		function int unsigned pending();
			return verdicts_due.size();
		endfunction

		// work out the verdict, if any, of one accepted input transfer
		function void note_transfer(udprc_pkg::in_item_t it);
			udprc_pkg::out_item_t r;
			int          hit;
			logic [7:0]  w8;
			logic [15:0] s;
			logic [15:0] comp;
			bit          ok;
			r = '0;
			hit = -1;
			case (it.mode)
				udprc_pkg::MODE_OPEN: begin
					// reuse a stored port first, else the lowest free entry
					for (int i = 0; i < udprc_pkg::TABLE_ENTRIES && hit < 0; i++)
						if (port_tab[i] == it.port_number) hit = i;
					if (hit < 0) begin
						for (int i = 0; i < udprc_pkg::TABLE_ENTRIES && hit < 0; i++)
							if (!port_live[i]) hit = i;
						if (hit >= 0) port_tab[hit] = it.port_number;
					end
					if (hit < 0) begin
						r.status = udprc_pkg::STAT_FULL;
					end else begin
						port_live[hit] = 1'b1;
						r.status = udprc_pkg::STAT_OPENED;
						r.entry_index = 4'(hit);
					end
					verdicts_due.push_back(r);
				end
				udprc_pkg::MODE_CLOSE: begin
					foreach (port_tab[i])
						if (port_tab[i] == it.port_number) port_live[i] = 1'b0;
					r.status = udprc_pkg::STAT_CLOSED;
					verdicts_due.push_back(r);
				end
				udprc_pkg::MODE_BYTE: begin
					// capture header fields, checksum bytes sum as zero
					w8 = it.data_byte;
					case (byte_cnt)
						16'd0: hdr_sport = {it.data_byte, 8'h00};
						16'd1: hdr_sport[7:0] = it.data_byte;
						16'd2: hdr_dport = {it.data_byte, 8'h00};
						16'd3: hdr_dport[7:0] = it.data_byte;
						16'd6: begin
							rx_sum = {it.data_byte, 8'h00};
							w8 = 8'h00;
						end
						16'd7: begin
							rx_sum[7:0] = it.data_byte;
							w8 = 8'h00;
						end
						default: ;
					endcase
					if (hi_pending) begin
						run_sum = ones_add(run_sum, {hi_byte, w8});
						hi_pending = 1'b0;
					end else begin
						hi_byte = w8;
						hi_pending = 1'b1;
					end
					if (byte_cnt != 16'hFFFF) byte_cnt = byte_cnt + 16'd1;
					if (it.last) begin
						if (byte_cnt < udprc_pkg::HEADER_BYTES) begin
							r.status = udprc_pkg::STAT_TOO_SHORT;
						end else begin
							// pad odd byte, then fold in the pseudo header
							s = run_sum;
							if (hi_pending) s = ones_add(s, {hi_byte, 8'h00});
							s = ones_add(s, it.source_ip[31:16]);
							s = ones_add(s, it.source_ip[15:0]);
							s = ones_add(s, local_ip[31:16]);
							s = ones_add(s, local_ip[15:0]);
							s = ones_add(s, udprc_pkg::UDP_PROTOCOL);
							s = ones_add(s, byte_cnt);
							comp = ~s;
							ok = (rx_sum == 16'h0000) || (rx_sum == comp) ||
								(comp == 16'h0000 && rx_sum == 16'hFFFF);
							r.source_port = hdr_sport;
							r.destination_port = hdr_dport;
							r.payload_length = byte_cnt - udprc_pkg::HEADER_BYTES;
							r.computed_sum = comp;
							if (!ok) begin
								r.status = udprc_pkg::STAT_BAD_SUM;
							end else begin
								for (int i = 0; i < udprc_pkg::TABLE_ENTRIES && hit < 0; i++)
									if (port_live[i] && port_tab[i] == hdr_dport) hit = i;
								if (hit < 0) begin
									r.status = udprc_pkg::STAT_UNREACHABLE;
								end else begin
									r.status = udprc_pkg::STAT_DELIVERED;
									r.entry_index = 4'(hit);
								end
							end
						end
						verdicts_due.push_back(r);
						clear_datagram();
					end
				end
				default: ;
			endcase
		endfunction

		task report_mismatch(string what, int unsigned got, int unsigned want);
			$display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
			mismatch_count++;
		endtask

		// compare one result transfer with the oldest expected verdict
		task check_verdict(udprc_pkg::out_item_t got);
			udprc_pkg::out_item_t want;
			if (verdicts_due.size() == 0) begin
				report_mismatch("result with no verdict due, status", got.status, 0);
				return;
			end
			want = verdicts_due.pop_front();
			if (got.status != want.status)
				report_mismatch("status", got.status, want.status);
			if (got.entry_index != want.entry_index)
				report_mismatch("entry_index", got.entry_index, want.entry_index);
			if (got.source_port != want.source_port)
				report_mismatch("source_port", got.source_port, want.source_port);
			if (got.destination_port != want.destination_port)
				report_mismatch("destination_port", got.destination_port,
					want.destination_port);
			if (got.payload_length != want.payload_length)
				report_mismatch("payload_length", got.payload_length, want.payload_length);
			if (got.computed_sum != want.computed_sum)
				report_mismatch("computed_sum", got.computed_sum, want.computed_sum);
		endtask
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	udprc_pkg::in_item_t  in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	udprc_pkg::out_item_t out_data;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;

	verdict_board sb;
	int unsigned  send_idle_pct = 20;
	int unsigned  recv_idle_pct = 77;
	int unsigned  items_sent = 0;
	logic [15:0]  port_pool[POOL_SIZE];

	udp_receive_checker_demux_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// result side: check transfers, stall at random
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_verdict(out_data);
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog on cycles with no transfer on either side
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	function automatic udprc_pkg::in_item_t byte_item(logic [7:0] b, logic fin,
		logic [31:0] src);
		udprc_pkg::in_item_t it;
		it.mode = udprc_pkg::MODE_BYTE;
		it.data_byte = b;
		it.last = fin;
		it.source_ip = src;
		it.port_number = 16'($urandom);
		return it;
	endfunction

	function automatic udprc_pkg::in_item_t table_item(logic [1:0] mode, logic [15:0] port);
		udprc_pkg::in_item_t it;
		it.mode = mode;
		it.data_byte = 8'($urandom);
		it.last = 1'($urandom);
		it.source_ip = $urandom;
		it.port_number = port;
		return it;
	endfunction

	// checksum a sender would put in the header, checksum field taken as is
	function automatic logic [15:0] dgram_checksum(logic [7:0] q[$], logic [31:0] src,
		logic [31:0] lip);
		logic [15:0] acc;
		logic [15:0] word;
		acc = '0;
		for (int i = 0; i < q.size(); i += 2) begin
			word = {q[i], (i + 1 < q.size()) ? q[i + 1] : 8'h00};
			acc = verdict_board::ones_add(acc, word);
		end
		acc = verdict_board::ones_add(acc, src[31:16]);
		acc = verdict_board::ones_add(acc, src[15:0]);
		acc = verdict_board::ones_add(acc, lip[31:16]);
		acc = verdict_board::ones_add(acc, lip[15:0]);
		acc = verdict_board::ones_add(acc, udprc_pkg::UDP_PROTOCOL);
		acc = verdict_board::ones_add(acc, 16'(q.size()));
		return ~acc;
	endfunction

	// datagram bytes with header and a checksum field per plan
	task automatic build_datagram(output logic [7:0] q[$], input logic [15:0] sport,
		input logic [15:0] dport, input logic [31:0] src, input int unsigned n,
		input sum_plan_t plan);
		logic [15:0] cs;
		logic [15:0] len_field;
		q = {};
		repeat (n) q.push_back(8'($urandom));
		if (n >= 8) begin
			len_field = ($urandom_range(9) == 0) ? 16'($urandom) : 16'(n);
			q[0] = sport[15:8];
			q[1] = sport[7:0];
			q[2] = dport[15:8];
			q[3] = dport[7:0];
			q[4] = len_field[15:8];
			q[5] = len_field[7:0];
			q[6] = 8'h00;
			q[7] = 8'h00;
			if (plan == SUM_ZERO_RESULT && n >= 10) begin
				// pick the first payload word so the computed sum comes out zero
				q[8] = 8'h00;
				q[9] = 8'h00;
				cs = dgram_checksum(q, src, sb.local_ip);
				q[8] = cs[15:8];
				q[9] = cs[7:0];
				cs = 16'hFFFF;
			end else begin
				case (plan)
					SUM_ABSENT: cs = 16'h0000;
					SUM_BAD: cs = dgram_checksum(q, src, sb.local_ip) ^
						16'($urandom_range(65535, 1));
					default: begin
						cs = dgram_checksum(q, src, sb.local_ip);
						if (cs == 16'h0000) cs = 16'hFFFF;
					end
				endcase
			end
			q[6] = cs[15:8];
			q[7] = cs[7:0];
		end
	endtask

	// one input transfer, with random idle cycles ahead of it
	task automatic send_item(input udprc_pkg::in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_transfer(it);
		if (it.mode != MODE_UNUSED) items_sent++;
	endtask

	task automatic random_table_op();
		logic [15:0] port;
		port = ($urandom_range(9) == 0) ? 16'($urandom)
			: port_pool[$urandom_range(POOL_SIZE - 1)];
		send_item(table_item(($urandom_range(99) < 65) ? udprc_pkg::MODE_OPEN
			: udprc_pkg::MODE_CLOSE, port));
	endtask

	// datagram bytes, with table items slipped in between them
	task automatic stream_datagram(input logic [7:0] q[$], input logic [31:0] src,
		input int unsigned mix_pct);
		for (int i = 0; i < q.size(); i++) begin
			if ($urandom_range(99) < mix_pct) random_table_op();
			send_item(byte_item(q[i], i == q.size() - 1, src));
		end
	endtask

	// random mix: mostly well-formed datagrams, some table items and noise
	task automatic random_step();
		int unsigned roll;
		int unsigned n;
		logic [15:0] dport;
		logic [31:0] src;
		sum_plan_t   plan;
		logic [7:0]  q[$];
		roll = $urandom_range(99);
		if (roll < 2) begin
			send_item(table_item(MODE_UNUSED, 16'($urandom)));
		end else if (roll < 16) begin
			random_table_op();
		end else begin
			roll = $urandom_range(99);
			if (roll < 10) n = $urandom_range(7, 1);
			else if (roll < 15) n = $urandom_range(300, 33);
			else n = $urandom_range(40, 8);
			dport = ($urandom_range(9) < 7) ? port_pool[$urandom_range(POOL_SIZE - 1)]
				: 16'($urandom);
			src = $urandom;
			roll = $urandom_range(9);
			plan = (roll < 5) ? SUM_GOOD : (roll == 5) ? SUM_ABSENT
				: (roll < 8) ? SUM_BAD : SUM_ZERO_RESULT;
			build_datagram(q, 16'($urandom), dport, src, n, plan);
			stream_datagram(q, src, 4);
		end
	endtask

	// drop valid, wait out all verdicts and the pseudo header fold
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_local_ip(input logic [31:0] ip);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= ip;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.local_ip = ip;
	endtask

	// main sequence
	initial begin
		logic [7:0]  q[$];
		logic [31:0] ip_plan[3];
		int unsigned goal;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: too short, ignored mode, open into a free entry
		send_item(byte_item(8'hFF, 1'b1, 32'hFFFF_FFFF));
		send_item(table_item(MODE_UNUSED, 16'h0000));
		send_item(table_item(udprc_pkg::MODE_OPEN, 16'hFFFF));

		// directed: computed sum zero against 0xffff, open slipped mid-datagram
		build_datagram(q, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 10, SUM_ZERO_RESULT);
		foreach (q[i]) begin
			if (i == 4) send_item(table_item(udprc_pkg::MODE_OPEN, 16'h0000));
			send_item(byte_item(q[i], i == q.size() - 1, 32'hFFFF_FFFF));
		end

		// directed: close, then odd length with checksum absent to a closed port
		send_item(table_item(udprc_pkg::MODE_CLOSE, 16'hFFFF));
		build_datagram(q, 16'h0000, 16'hFFFF, 32'h0000_0000, 9, SUM_ABSENT);
		stream_datagram(q, 32'h0000_0000, 0);

		// random phases, each under its own address and idle pattern
		ip_plan[0] = 32'hFFFF_FFFF;
		ip_plan[1] = $urandom;
		ip_plan[2] = 32'h0000_0000;
		for (int ph = 0; ph < 3; ph++) begin
			settle();
			send_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 77 : 0;
			recv_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 20 : 0;
			write_local_ip(ip_plan[ph]);
			port_pool[0] = 16'h0000;
			port_pool[1] = 16'hFFFF;
			for (int i = 2; i < POOL_SIZE; i++) port_pool[i] = 16'($urandom);
			goal = items_sent + PHASE_ITEMS;
			while (items_sent < goal) random_step();
		end

		settle();
		if (sb.mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
